>>> design/ihp_pkg.sv
// ihp_pkg: shared widths and codes for the indexed max-heap block.
// No dependencies; used by the channel interfaces and indexed_max_heap_top.
package ihp_pkg;

  // Fixed field widths of the command and result items
  localparam int unsigned CMD_W    = 3;
  localparam int unsigned ID_W     = 10;
  localparam int unsigned IDX_W    = 10;
  localparam int unsigned STAT_W   = 2;
  localparam int unsigned POS_W    = 10;
  localparam int unsigned CNT_W    = 11;
  localparam int unsigned ID_SLOTS = 1 << ID_W;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_PUSH   = 3'd0;
  localparam logic [CMD_W-1:0] CMD_REMOVE = 3'd1;
  localparam logic [CMD_W-1:0] CMD_READ   = 3'd2;
  localparam logic [CMD_W-1:0] CMD_LOCATE = 3'd3;
  localparam logic [CMD_W-1:0] CMD_CLEAR  = 3'd4;

  // Status codes
  localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STAT_W-1:0] STAT_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] STAT_RANGE = 2'd2;

endpackage

>>> design/ihp_if.sv
// ihp_if: valid/ready channel interfaces for command and result items.
// Depends on ihp_pkg for field widths.
interface ihp_cmd_if #(
  parameter int unsigned SCORE_BITS = 32
);
  import ihp_pkg::*;
  logic                         valid;
  logic                         ready;
  logic [CMD_W-1:0]             command;
  logic [ID_W-1:0]              entry_id;
  logic signed [SCORE_BITS-1:0] score;
  logic [IDX_W-1:0]             index;

  modport source (output valid, command, entry_id, score, index, input ready);
  modport sink   (input valid, command, entry_id, score, index, output ready);
endinterface

interface ihp_rsp_if #(
  parameter int unsigned SCORE_BITS = 32
);
  import ihp_pkg::*;
  logic                         valid;
  logic                         ready;
  logic [STAT_W-1:0]            status;
  logic [ID_W-1:0]              result_id;
  logic signed [SCORE_BITS-1:0] result_score;
  logic [POS_W-1:0]             position;
  logic [CNT_W-1:0]             entry_count;

  modport source (output valid, status, result_id, result_score, position, entry_count,
                  input ready);
  modport sink   (input valid, status, result_id, result_score, position, entry_count,
                  output ready);
endinterface

>>> design/indexed_max_heap_top.sv
// indexed_max_heap_top: binary max-heap priority queue with a per-id position table.
// Depends on ihp_pkg and the channel interfaces in ihp_if.sv.

// One command item is taken at a time and gives one result item. Entries live in
// a heap memory (id and score per slot) and positions in a 1024-entry table memory,
// both with registered reads. Read and locate read one memory and answer; push
// climbs level by level toward the root; remove moves the last entry into the hole
// and sifts it up or down, each level down taking two child reads and a compare/write
// on the single heap read port. Clear sweeps the position table, one entry a cycle;
// after reset the same sweep runs before the first command is taken. A new command
// is taken while the previous result still waits in the output register.
module indexed_max_heap_top #(
  parameter int unsigned CAPACITY   = 1024,
  parameter int unsigned SCORE_BITS = 32
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  ihp_cmd_if.sink   cmd_i,
  ihp_rsp_if.source rsp_o
);
  import ihp_pkg::*;

  localparam int unsigned PW  = (CAPACITY > 2) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW  = $clog2(CAPACITY + 1);
  localparam int unsigned XW  = (CW > IDX_W) ? CW : IDX_W;
  localparam int unsigned LW  = CW + 1;
  localparam int unsigned SB  = SCORE_BITS;
  localparam int unsigned HW  = ID_W + SB;
  localparam int unsigned TW  = PW + 1;

  typedef enum logic [11:0] {
    ST_IDLE   = 12'b0000_0000_0001,
    ST_CLR    = 12'b0000_0000_0010,
    ST_RD     = 12'b0000_0000_0100,
    ST_RM1    = 12'b0000_0000_1000,
    ST_RM2    = 12'b0000_0001_0000,
    ST_LOC    = 12'b0000_0010_0000,
    ST_UP     = 12'b0000_0100_0000,
    ST_DN_L   = 12'b0000_1000_0000,
    ST_DN_R   = 12'b0001_0000_0000,
    ST_DN_CMP = 12'b0010_0000_0000,
    ST_FIN    = 12'b0100_0000_0000,
    ST_OUT    = 12'b1000_0000_0000
  } state_e;

  state_e state_q, state_d;

  // Heap memory: {id, score} per slot; position table: {valid, position} per id
  logic [HW-1:0] hm_mem [CAPACITY];
  logic [TW-1:0] pt_mem [ID_SLOTS];
  logic [HW-1:0] hm_rdata;
  logic [TW-1:0] pt_rdata;
  logic [PW-1:0] hm_raddr, hm_waddr;
  logic [HW-1:0] hm_wdata;
  logic          hm_we;
  logic [ID_W-1:0] pt_raddr, pt_waddr;
  logic [TW-1:0] pt_wdata;
  logic          pt_we;

  // Working registers
  logic [CW-1:0]   total_q, total_d;
  logic [PW-1:0]   i_q, i_d;
  logic [ID_W-1:0] m_id_q, m_id_d;
  logic [SB-1:0]   m_sc_q, m_sc_d;
  logic [ID_W-1:0] c_id_q, c_id_d;
  logic [SB-1:0]   c_sc_q, c_sc_d;
  logic [PW-1:0]   c_idx_q, c_idx_d;
  logic [ID_W-1:0] rem_id_q, rem_id_d;
  logic [IDX_W-1:0] idx_q, idx_d;
  logic            rm_mode_q, rm_mode_d;
  logic            moved_q, moved_d;
  logic [ID_W-1:0] clr_cnt_q, clr_cnt_d;
  logic            clr_rpt_q, clr_rpt_d;

  // Result being built and the output register
  logic [STAT_W-1:0] stat_q, stat_d;
  logic [ID_W-1:0]   rid_q, rid_d;
  logic [SB-1:0]     rsc_q, rsc_d;
  logic [PW-1:0]     pos_q, pos_d;
  logic              out_valid_q, out_valid_d;
  logic [STAT_W-1:0] o_stat_q;
  logic [ID_W-1:0]   o_rid_q;
  logic [SB-1:0]     o_rsc_q;
  logic [PW-1:0]     o_pos_q;
  logic [CW-1:0]     o_cnt_q;
  logic              out_load;

  // Read data split
  logic [ID_W-1:0] rd_id;
  logic [SB-1:0]   rd_sc;
  assign rd_id = hm_rdata[HW-1:SB];
  assign rd_sc = hm_rdata[SB-1:0];

  // Index helpers
  logic [PW-1:0] up_p, up_pp, push_p;
  logic [PW-1:0] dn_base;
  logic [LW-1:0] dn_l, cur_l, cur_r;
  logic          dn_go, cur_r_ok;
  logic [CW-1:0] last_k;
  logic          cmd_range_bad, cmd_full;

  assign up_p    = (i_q - PW'(1)) >> 1;
  assign up_pp   = (up_p - PW'(1)) >> 1;
  assign push_p  = (PW'(total_q) - PW'(1)) >> 1;
  assign dn_base = (state_q == ST_DN_CMP) ? c_idx_q : i_q;
  assign dn_l    = LW'({dn_base, 1'b1});
  assign dn_go   = dn_l < LW'(total_q);
  assign cur_l   = LW'({i_q, 1'b1});
  assign cur_r   = cur_l + LW'(1);
  assign cur_r_ok = cur_r < LW'(total_q);
  assign last_k  = total_q - CW'(1);
  assign cmd_range_bad = XW'(cmd_i.index) >= XW'(total_q);
  assign cmd_full      = total_q >= CW'(CAPACITY);

  assign cmd_i.ready = (state_q == ST_IDLE);

  // Memories with registered read
  always_ff @(posedge clk_i) begin
    if (hm_we) begin
      hm_mem[hm_waddr] <= hm_wdata;
    end
    hm_rdata <= hm_mem[hm_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (pt_we) begin
      pt_mem[pt_waddr] <= pt_wdata;
    end
    pt_rdata <= pt_mem[pt_raddr];
  end

  // Command sequencer
  always_comb begin
    state_d   = state_q;
    total_d   = total_q;
    i_d       = i_q;
    m_id_d    = m_id_q;
    m_sc_d    = m_sc_q;
    c_id_d    = c_id_q;
    c_sc_d    = c_sc_q;
    c_idx_d   = c_idx_q;
    rem_id_d  = rem_id_q;
    idx_d     = idx_q;
    rm_mode_d = rm_mode_q;
    moved_d   = moved_q;
    clr_cnt_d = clr_cnt_q;
    clr_rpt_d = clr_rpt_q;
    stat_d    = stat_q;
    rid_d     = rid_q;
    rsc_d     = rsc_q;
    pos_d     = pos_q;
    hm_raddr  = '0;
    hm_we     = 1'b0;
    hm_waddr  = i_q;
    hm_wdata  = {m_id_q, m_sc_q};
    pt_raddr  = cmd_i.entry_id;
    pt_we     = 1'b0;
    pt_waddr  = m_id_q;
    pt_wdata  = {1'b1, i_q};
    out_load  = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (cmd_i.valid) begin
          stat_d  = STAT_OK;
          rid_d   = '0;
          rsc_d   = '0;
          pos_d   = '0;
          moved_d = 1'b0;
          idx_d   = cmd_i.index;
          m_id_d  = cmd_i.entry_id;
          m_sc_d  = cmd_i.score;
          unique case (cmd_i.command)
            CMD_PUSH: begin
              rm_mode_d = 1'b0;
              if (cmd_full) begin
                stat_d  = STAT_FULL;
                state_d = ST_OUT;
              end else begin
                i_d     = PW'(total_q);
                total_d = total_q + CW'(1);
                if (total_q == '0) begin
                  state_d = ST_FIN;
                end else begin
                  hm_raddr = push_p;
                  state_d  = ST_UP;
                end
              end
            end
            CMD_REMOVE, CMD_READ: begin
              rm_mode_d = 1'b1;
              if (cmd_range_bad) begin
                stat_d  = STAT_RANGE;
                state_d = ST_OUT;
              end else begin
                hm_raddr = PW'(cmd_i.index);
                state_d  = (cmd_i.command == CMD_READ) ? ST_RD : ST_RM1;
              end
            end
            CMD_LOCATE: begin
              state_d = ST_LOC;
            end
            CMD_CLEAR: begin
              total_d   = '0;
              clr_cnt_d = '0;
              clr_rpt_d = 1'b1;
              state_d   = ST_CLR;
            end
            default: begin
              state_d = ST_OUT;
            end
          endcase
        end
      end

      // Sweep the position table to absent
      ST_CLR: begin
        pt_we     = 1'b1;
        pt_waddr  = clr_cnt_q;
        pt_wdata  = '0;
        clr_cnt_d = clr_cnt_q + ID_W'(1);
        if (clr_cnt_q == '1) begin
          state_d = clr_rpt_q ? ST_OUT : ST_IDLE;
        end
      end

      ST_RD: begin
        rid_d   = rd_id;
        rsc_d   = rd_sc;
        state_d = ST_OUT;
      end

      ST_LOC: begin
        if (!pt_rdata[PW] || (CW'(pt_rdata[PW-1:0]) >= total_q)) begin
          stat_d = STAT_RANGE;
        end else begin
          pos_d = pt_rdata[PW-1:0];
        end
        state_d = ST_OUT;
      end

      // Removed entry is in; mark it absent and fetch the last entry unless it was the last
      ST_RM1: begin
        rid_d    = rd_id;
        rsc_d    = rd_sc;
        rem_id_d = rd_id;
        pt_we    = 1'b1;
        pt_waddr = rd_id;
        pt_wdata = '0;
        total_d  = last_k;
        i_d      = PW'(idx_q);
        if (XW'(idx_q) == XW'(last_k)) begin
          state_d = ST_OUT;
        end else begin
          hm_raddr = PW'(last_k);
          state_d  = ST_RM2;
        end
      end

      // Last entry fills the hole at the removed index
      ST_RM2: begin
        m_id_d = rd_id;
        m_sc_d = rd_sc;
        if (i_q == '0) begin
          if (dn_go) begin
            hm_raddr = PW'(dn_l);
            state_d  = ST_DN_L;
          end else begin
            state_d = ST_FIN;
          end
        end else begin
          hm_raddr = up_p;
          state_d  = ST_UP;
        end
      end

      // Sift up: parent data is in
      ST_UP: begin
        if ($signed(m_sc_q) > $signed(rd_sc)) begin
          hm_we    = 1'b1;
          hm_waddr = i_q;
          hm_wdata = hm_rdata;
          pt_we    = 1'b1;
          pt_waddr = rd_id;
          pt_wdata = {1'b1, i_q};
          moved_d  = 1'b1;
          i_d      = up_p;
          if (up_p != '0) begin
            hm_raddr = up_pp;
          end else begin
            state_d = ST_FIN;
          end
        end else if (rm_mode_q && !moved_q) begin
          if (dn_go) begin
            hm_raddr = PW'(dn_l);
            state_d  = ST_DN_L;
          end else begin
            state_d = ST_FIN;
          end
        end else begin
          state_d = ST_FIN;
        end
      end

      // Sift down: left child is in
      ST_DN_L: begin
        c_id_d  = rd_id;
        c_sc_d  = rd_sc;
        c_idx_d = PW'(cur_l);
        if (cur_r_ok) begin
          hm_raddr = PW'(cur_r);
          state_d  = ST_DN_R;
        end else begin
          state_d = ST_DN_CMP;
        end
      end

      // Right child wins only when strictly larger
      ST_DN_R: begin
        if ($signed(rd_sc) > $signed(c_sc_q)) begin
          c_id_d  = rd_id;
          c_sc_d  = rd_sc;
          c_idx_d = PW'(cur_r);
        end
        state_d = ST_DN_CMP;
      end

      ST_DN_CMP: begin
        if ($signed(c_sc_q) > $signed(m_sc_q)) begin
          hm_we    = 1'b1;
          hm_waddr = i_q;
          hm_wdata = {c_id_q, c_sc_q};
          pt_we    = 1'b1;
          pt_waddr = c_id_q;
          pt_wdata = {1'b1, i_q};
          moved_d  = 1'b1;
          i_d      = c_idx_q;
          if (dn_go) begin
            hm_raddr = PW'(dn_l);
            state_d  = ST_DN_L;
          end else begin
            state_d = ST_FIN;
          end
        end else begin
          state_d = ST_FIN;
        end
      end

      // Drop the moving entry into its final slot
      ST_FIN: begin
        hm_we    = 1'b1;
        hm_waddr = i_q;
        hm_wdata = {m_id_q, m_sc_q};
        pt_we    = !rm_mode_q || moved_q || (m_id_q != rem_id_q);
        pt_waddr = m_id_q;
        pt_wdata = {1'b1, i_q};
        if (!rm_mode_q) begin
          pos_d = i_q;
        end
        state_d = ST_OUT;
      end

      ST_OUT: begin
        if (!out_valid_q || rsp_o.ready) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign out_valid_d = out_load | (out_valid_q & ~rsp_o.ready);

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLR;
      total_q     <= '0;
      clr_cnt_q   <= '0;
      clr_rpt_q   <= 1'b0;
      rm_mode_q   <= 1'b0;
      moved_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      total_q     <= total_d;
      clr_cnt_q   <= clr_cnt_d;
      clr_rpt_q   <= clr_rpt_d;
      rm_mode_q   <= rm_mode_d;
      moved_q     <= moved_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    i_q      <= i_d;
    m_id_q   <= m_id_d;
    m_sc_q   <= m_sc_d;
    c_id_q   <= c_id_d;
    c_sc_q   <= c_sc_d;
    c_idx_q  <= c_idx_d;
    rem_id_q <= rem_id_d;
    idx_q    <= idx_d;
    stat_q   <= stat_d;
    rid_q    <= rid_d;
    rsc_q    <= rsc_d;
    pos_q    <= pos_d;
    if (out_load) begin
      o_stat_q <= stat_q;
      o_rid_q  <= rid_q;
      o_rsc_q  <= rsc_q;
      o_pos_q  <= pos_q;
      o_cnt_q  <= total_q;
    end
  end

  assign rsp_o.valid        = out_valid_q;
  assign rsp_o.status       = o_stat_q;
  assign rsp_o.result_id    = o_rid_q;
  assign rsp_o.result_score = o_rsc_q;
  assign rsp_o.position     = POS_W'(o_pos_q);
  assign rsp_o.entry_count  = CNT_W'(o_cnt_q);

endmodule
